/* rtl/llf_pkg.sv */
// Shared constants, command and status types for the linear level fader.
`default_nettype none

package llf_pkg;

  // Refresh tick spacing in milliseconds and fraction bits of the level.
  localparam int REFRESH_MS = 1;
  localparam int FRAC_BITS  = 16;

  // Field and register widths.
  localparam int MS_W   = 16;
  localparam int RAW_W  = 16;
  localparam int TGT_W  = 9;
  localparam int OUT_W  = 8;
  localparam int LVL_W  = OUT_W + FRAC_BITS;
  localparam int STEP_W = LVL_W + 1;
  localparam int SUM_W  = LVL_W + 2;
  localparam int PROD_W = MS_W + LVL_W;
  localparam int SPAN_W = PROD_W - FRAC_BITS;

  // Divisor of the full-range step count, without the fraction scaling.
  localparam int FULL_DIV = 255 * REFRESH_MS;

  // Shared divider: numerator, divisor and iteration sizes.
  localparam int NUM_W     = (SPAN_W > LVL_W) ? SPAN_W : LVL_W;
  localparam int DIV_BITS  = 2;
  localparam int DIV_ITERS = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int QUO_W     = DIV_ITERS * DIV_BITS;
  localparam int FDIV_W    = $clog2(FULL_DIV + 1);
  localparam int DEN_W     = (FDIV_W > MS_W) ? FDIV_W : MS_W;
  localparam int CNT_W     = $clog2(DIV_ITERS + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_UP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

  localparam logic [MS_W-1:0] FADE_MS_RST = 16'd300;

  // Request kinds.
  localparam logic REQ_TARGET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SETUP,
    ST_MUL,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_DIV2_WAIT,
    ST_STEP,
    ST_JUMP
  } llf_state_e;

  typedef struct packed {
    logic capture;
    logic setup;
    logic mul;
    logic div1_start;
    logic div2_start;
    logic load_step;
    logic step;
    logic jump;
  } llf_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic fading;
    logic same_target;
    logic div_done;
    logic steps_zero;
    logic slot_free;
  } llf_sts_t;

endpackage

`default_nettype wire

/* rtl/llf_req_if.sv */
// Request channel: a new target or a refresh tick.
`default_nettype none

interface llf_req_if import llf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [RAW_W-1:0] target_value;

  modport source (output valid, output req_type, output target_value, input ready);
  modport sink   (input valid, input req_type, input target_value, output ready);
endinterface

`default_nettype wire

/* rtl/llf_out_if.sv */
// Result channel: the new integer output level.
`default_nettype none

interface llf_out_if import llf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] level_out;

  modport source (output valid, output level_out, input ready);
  modport sink   (input valid, input level_out, output ready);
endinterface

`default_nettype wire

/* rtl/llf_div.sv */
// Restoring divider that retires DIV_BITS quotient bits per cycle.
`default_nettype none

module llf_div import llf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [QUO_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quo_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_d = {rem_d[DEN_W-1:0], quo_d[QUO_W-1]};
      quo_d = {quo_d[QUO_W-2:0], 1'b0};
      if (rem_d >= {1'b0, den_q}) begin
        rem_d    = rem_d - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_ITERS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // The finish pulse follows the last iteration, never a running one.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider reports done while still iterating");

endmodule

`default_nettype wire

/* rtl/llf_ctrl.sv */
// Sequencing state machine of the fader.
`default_nettype none

module llf_ctrl import llf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire llf_sts_t sts_i,
  output llf_cmd_t      cmd_o
);

  llf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_tick) begin
          state_d = sts_i.fading ? ST_STEP : ST_IDLE;
        end else if (sts_i.same_target) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV1_GO;
      end
      ST_DIV1_GO: begin
        cmd_o.div1_start = 1'b1;
        state_d          = ST_DIV1_WAIT;
      end
      ST_DIV1_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.steps_zero) begin
            state_d = ST_JUMP;
          end else begin
            cmd_o.div2_start = 1'b1;
            state_d          = ST_DIV2_WAIT;
          end
        end
      end
      ST_DIV2_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.load_step = 1'b1;
          state_d         = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts_i.slot_free) begin
          cmd_o.step = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_JUMP: begin
        if (sts_i.slot_free) begin
          cmd_o.jump = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A level update may only be committed when the output register can take it.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step || cmd_o.jump) |-> sts_i.slot_free)
    else $error("level committed while the output register is occupied");

  // Divider results only arrive while the sequencer is waiting for them.
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_DIV1_WAIT || state_q == ST_DIV2_WAIT))
    else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

/* rtl/llf_dp.sv */
// Datapath of the fader: settings, fade state, step arithmetic and output register.
`default_nettype none

module llf_dp import llf_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [MS_W-1:0]         cfg_wdata_i,
  input  wire logic                    in_req_type_i,
  input  wire logic signed [RAW_W-1:0] in_target_value_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic [OUT_W-1:0]             out_level_o,
  input  wire llf_cmd_t                cmd_i,
  output llf_sts_t                     sts_o
);

  // Settings.
  logic [MS_W-1:0] fade_up_q, fade_down_q;
  logic            mode_q;

  // Fade state.
  logic [LVL_W-1:0]         level_q, level_d;
  logic signed [STEP_W-1:0] step_q, step_d;
  logic [TGT_W-1:0]         target_q;
  logic [TGT_W-1:0]         last_q, last_d;
  logic                     fading_q, fading_d;

  // Captured request and working values.
  logic                    req_type_q;
  logic signed [RAW_W-1:0] raw_q;
  logic [LVL_W-1:0]        mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [MS_W-1:0]         dur_q, dur_d;
  logic [PROD_W-1:0]       prod_q;

  // Output register.
  logic             out_valid_q;
  logic [OUT_W-1:0] out_level_q;

  // Divider connections.
  logic             div_start, div_done;
  logic [QUO_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  logic [OUT_W-1:0]        clamp;
  logic [LVL_W-1:0]        new_fix, cur_fix;
  logic [LVL_W-1:0]        q_mag;
  logic signed [SUM_W-1:0] sum, tgt_ext;
  logic                    step_pos, step_neg, cont;
  logic [OUT_W-1:0]        whole;
  logic                    emit;
  logic                    slot_free;

  // Clamp the raw request into the level range; find the distance, direction and fade time.
  always_comb begin
    if (raw_q[RAW_W-1]) begin
      clamp = '0;
    end else if (raw_q[RAW_W-2:OUT_W] != '0) begin
      clamp = '1;
    end else begin
      clamp = raw_q[OUT_W-1:0];
    end
    new_fix = {clamp, {FRAC_BITS{1'b0}}};
    neg_d   = level_q > new_fix;
    mag_d   = neg_d ? (level_q - new_fix) : (new_fix - level_q);
    dur_d   = (level_q < new_fix) ? fade_up_q : fade_down_q;
  end

  // Step count first, then the step size from the same divider.
  assign div_start = cmd_i.div1_start || cmd_i.div2_start;
  always_comb begin
    if (cmd_i.div2_start) begin
      div_num = QUO_W'(mag_q);
      div_den = div_quo[DEN_W-1:0];
    end else if (mode_q) begin
      div_num = QUO_W'(prod_q[PROD_W-1:FRAC_BITS]);
      div_den = DEN_W'(FULL_DIV);
    end else begin
      div_num = QUO_W'(dur_q);
      div_den = DEN_W'(REFRESH_MS);
    end
  end

  llf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // A nonzero distance always moves by at least one LSB.
  always_comb begin
    q_mag = div_quo[LVL_W-1:0];
    if (q_mag == '0 && mag_q != '0) begin
      q_mag = LVL_W'(1);
    end
    step_d = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  // One step of the fade, snapping to the target once it is reached or passed.
  always_comb begin
    cur_fix  = {target_q[OUT_W-1:0], {FRAC_BITS{1'b0}}};
    sum      = $signed({2'b00, level_q}) +
               $signed({{(SUM_W-STEP_W){step_q[STEP_W-1]}}, step_q});
    tgt_ext  = $signed({2'b00, cur_fix});
    step_neg = step_q[STEP_W-1];
    step_pos = !step_neg && (step_q != '0);
    cont     = ((sum < tgt_ext) && step_pos) || ((sum > tgt_ext) && step_neg);
    level_d  = cont ? sum[LVL_W-1:0] : cur_fix;
    fading_d = cont;
    whole    = level_d[LVL_W-1:FRAC_BITS];
    emit     = {1'b0, whole} != last_q;
    last_d   = emit ? {1'b0, whole} : last_q;
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_up_q   <= FADE_MS_RST;
      fade_down_q <= FADE_MS_RST;
      mode_q      <= 1'b0;
      level_q     <= '0;
      step_q      <= '0;
      target_q    <= '1;
      last_q      <= '1;
      fading_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FADE_UP:   fade_up_q   <= cfg_wdata_i;
          CFG_FADE_DOWN: fade_down_q <= cfg_wdata_i;
          CFG_MODE:      mode_q      <= cfg_wdata_i[0];
          default:       ;
        endcase
      end
      if (cmd_i.setup) begin
        target_q <= {1'b0, clamp};
      end
      if (cmd_i.load_step) begin
        step_q   <= step_d;
        last_q   <= '1;
        fading_q <= 1'b1;
      end
      if (cmd_i.step) begin
        level_q  <= level_d;
        fading_q <= fading_d;
        last_q   <= last_d;
      end
      if (cmd_i.jump) begin
        level_q  <= cur_fix;
        fading_q <= 1'b0;
        last_q   <= '1;
      end
      if ((cmd_i.step && emit) || cmd_i.jump) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= in_req_type_i;
      raw_q      <= in_target_value_i;
    end
    if (cmd_i.setup) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      dur_q <= dur_d;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(dur_q) * PROD_W'(mag_q);
    end
    if (cmd_i.step && emit) begin
      out_level_q <= whole;
    end else if (cmd_i.jump) begin
      out_level_q <= target_q[OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_level_o = out_level_q;

  always_comb begin
    sts_o             = '0;
    sts_o.is_tick     = (req_type_q == REQ_TICK);
    sts_o.fading      = fading_q;
    sts_o.same_target = (raw_q == $signed({{(RAW_W-TGT_W){target_q[TGT_W-1]}}, target_q}));
    sts_o.div_done    = div_done;
    sts_o.steps_zero  = (div_quo == '0);
    sts_o.slot_free   = slot_free;
  end

  // A running fade always heads for a real target, never the reset marker.
  a_fade_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fading_q |-> !target_q[TGT_W-1])
    else $error("fade running without a valid target");

endmodule

`default_nettype wire

/* rtl/linear_level_fader.sv */
// Top level of the linear level fader: controller, datapath and channel wiring.
//
// The block moves an 8-bit output level toward a requested target in equal
// fixed-point steps. Requests arrive on req_i: req_type 0 carries a new raw
// target in target_value, req_type 1 is a refresh tick that advances a
// running fade by one step. Each new integer level leaves on res_o.
// Both channels use valid/ready; a request is taken when both are high.
// A new target runs through a multiply and one or two passes of the shared
// divider (two quotient bits per cycle); the second pass, for the step size,
// is skipped when the step count is zero. One request is worked on at a time,
// and req_i is ready again as soon as the previous one is done.
// The result sits in an output register, so a new request is accepted while
// a level still waits on res_o. If the receiver stalls, the next level update
// waits until that register is free; nothing is dropped.
// Settings are to be written through cfg_we_i, cfg_idx_i and cfg_wdata_i only
// while the block is idle; the block itself does not enforce this. Reset sets
// both fade times to 300 ms, per-fade timing, level zero and no target.
`default_nettype none

module linear_level_fader import llf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  llf_req_if.sink                   req_i,
  llf_out_if.source                 res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [MS_W-1:0]      cfg_wdata_i
);

  llf_cmd_t cmd;
  llf_sts_t sts;
  logic     in_ready;

  // The controller decides when a request is taken and which datapath
  // operation runs in each cycle.
  llf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  // The datapath holds the settings, the fade state and the output register.
  llf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_req_type_i     (req_i.req_type),
    .in_target_value_i (req_i.target_value),
    .out_ready_i       (res_o.ready),
    .out_valid_o       (res_o.valid),
    .out_level_o       (res_o.level_out),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

`default_nettype wire
